// ----- design/jtl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and character helpers of the JSON token lexer.
// Depends on nothing; the lexer and the checker take from it by scoped names, the bench imports it.
package jtl_pkg;

  typedef enum logic [2:0] {
    MODE_BASE   = 3'd0,
    MODE_STRING = 3'd1,
    MODE_NUMBER = 3'd2,
    MODE_TRUE   = 3'd3,
    MODE_FALSE  = 3'd4,
    MODE_NULL   = 3'd5,
    MODE_ERROR  = 3'd6
  } mode_t;

  localparam logic [3:0] KIND_LBRACE    = 4'd0;
  localparam logic [3:0] KIND_RBRACE    = 4'd1;
  localparam logic [3:0] KIND_LBRACKET  = 4'd2;
  localparam logic [3:0] KIND_RBRACKET  = 4'd3;
  localparam logic [3:0] KIND_STRING    = 4'd4;
  localparam logic [3:0] KIND_STR_PART  = 4'd5;
  localparam logic [3:0] KIND_NUMBER    = 4'd6;
  localparam logic [3:0] KIND_NUM_PART  = 4'd7;
  localparam logic [3:0] KIND_SMALL_NUM = 4'd8;
  localparam logic [3:0] KIND_TRUE      = 4'd9;
  localparam logic [3:0] KIND_FALSE     = 4'd10;
  localparam logic [3:0] KIND_NULL      = 4'd11;
  localparam logic [3:0] KIND_ERROR     = 4'd12;

  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_PRINT_LO = 8'd32;
  localparam logic [7:0] CH_PRINT_HI = 8'd126;

  localparam logic [4:0] DIGIT_CAP   = 5'd18;
  localparam logic [4:0] DIGITS_RST  = 5'd18;
  localparam int         FIFO_DEPTH  = 4;
  localparam int         FIFO_AW     = 2;

  typedef struct packed {
    logic [3:0]         token_kind;
    logic [15:0]        token_start;
    logic [16:0]        token_length;
    logic signed [60:0] extra_value;
    logic               last_of_run;
  } tok_t;

  function automatic tok_t mk_tok(input logic [3:0] kind, input logic [15:0] start,
                                  input logic [16:0] len, input logic [60:0] extra);
    tok_t t;
    t.token_kind   = kind;
    t.token_start  = start;
    t.token_length = len;
    t.extra_value  = extra;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  function automatic logic is_gap(input logic [7:0] b);
    return (b == 8'h3A) || (b == 8'h2C) || (b == 8'h20) || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_numch(input logic [7:0] b);
    return is_digit(b) || (b == CH_MINUS) || (b == CH_DOT) || (b == CH_PLUS) ||
           (b == 8'h65) || (b == 8'h45);
  endfunction

  // Expected byte of a literal word at a given index.
  function automatic logic [7:0] word_char(input mode_t m, input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (m)
      MODE_TRUE: begin
        case (idx)
          3'd0: c = 8'h74;
          3'd1: c = 8'h72;
          3'd2: c = 8'h75;
          3'd3: c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      MODE_FALSE: begin
        case (idx)
          3'd0: c = 8'h66;
          3'd1: c = 8'h61;
          3'd2: c = 8'h6C;
          3'd3: c = 8'h73;
          3'd4: c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      MODE_NULL: begin
        case (idx)
          3'd0: c = 8'h6E;
          3'd1: c = 8'h75;
          3'd2: c = 8'h6C;
          3'd3: c = 8'h6C;
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- design/jtl_in_if.sv -----
`timescale 1ns / 1ps
// Input channel of the JSON token lexer: one text byte per item.
// Stand-alone; no package needed.
interface jtl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_end;

  modport source(output valid, output data_byte, output chunk_end, input ready);
  modport sink(input valid, input data_byte, input chunk_end, output ready);
endinterface

// ----- design/jtl_out_if.sv -----
`timescale 1ns / 1ps
// Result channel of the JSON token lexer: one token per item.
// Stand-alone; no package needed.
interface jtl_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         token_kind;
  logic [15:0]        token_start;
  logic [16:0]        token_length;
  logic signed [60:0] extra_value;
  logic               last_of_run;

  modport source(output valid, output token_kind, output token_start, output token_length,
                 output extra_value, output last_of_run, input ready);
  modport sink(input valid, input token_kind, input token_start, input token_length,
               input extra_value, input last_of_run, output ready);
endinterface

// ----- design/json_token_lexer.sv -----
`timescale 1ns / 1ps
// A token goes into the token queue when the byte that causes it is accepted.
// Throughput: one byte per cycle; a byte yields zero, one or two tokens, and the
// four-entry token queue drains one token per cycle while out_if.ready is high, so
// in_if.ready drops only while more than two tokens are waiting there.
// Reset: rst_n is synchronous and active low; it clears the lexer state, empties the
// queue and sets max_digits back to 18. There is no clearing pass.
module json_token_lexer #(
  parameter longint unsigned MAX_CHUNK = 65536
) (
  input  logic            clk,
  input  logic            rst_n,
  jtl_in_if.sink          in_if,
  jtl_out_if.source       out_if,
  input  logic            cfg_we,
  input  logic [4:0]      cfg_wdata
);

  // Chunk positions saturate at MAX_CHUNK-1, so they need POS_W bits. A string's span
  // starts one past its quote and may reach MAX_CHUNK, hence one more bit there.
  // Length arithmetic is done in CW bits, which is at least the 17-bit field width,
  // so wraparound in the low bits matches modular arithmetic on the full values.
  localparam int POS_W = (MAX_CHUNK > 2) ? $clog2(MAX_CHUNK) : 1;
  localparam int CW    = (POS_W + 1 > 17) ? POS_W + 1 : 17;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CHUNK - 1);

  // Lexer state.
  jtl_pkg::mode_t   mode_r, mode_nxt;
  logic [2:0]       idx_r, idx_nxt;
  logic             esc_r, esc_nxt;
  logic             cont_r, cont_nxt;
  logic             spec_r, spec_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W:0]   ss_r, ss_nxt;
  logic [59:0]      acc_r, acc_nxt;
  logic [4:0]       dcnt_r, dcnt_nxt;
  logic             dot_r, dot_nxt;
  logic [4:0]       frac_r, frac_nxt;
  logic             neg_r, neg_nxt;
  logic             inv_r, inv_nxt;
  logic [4:0]       max_digits_r;

  // Token queue between the lexer and the result channel.
  jtl_pkg::tok_t              q_mem [jtl_pkg::FIFO_DEPTH];
  logic [jtl_pkg::FIFO_AW-1:0] wp_r, rp_r;
  logic [jtl_pkg::FIFO_AW:0]   cnt_r;

  jtl_pkg::tok_t res_v [2];
  logic [1:0]    nres;
  logic          accept, pop;
  logic [4:0]    lim;

  assign accept = in_if.valid && in_if.ready;
  assign pop    = out_if.valid && out_if.ready;

  // Space for two more tokens is kept free, since one byte can produce two.
  assign in_if.ready = (cnt_r <= (jtl_pkg::FIFO_AW + 1)'(jtl_pkg::FIFO_DEPTH - 2));
  assign lim = (max_digits_r > jtl_pkg::DIGIT_CAP) ? jtl_pkg::DIGIT_CAP : max_digits_r;

  // All work for one byte: the old state and the byte give the next state and up to
  // two tokens. The steps follow one another in the same order as the lexer rules:
  // string body, then literal word, then number end, then base byte, then number body.
  always_comb begin
    logic [7:0]    b;
    logic          e;
    logic          closed;
    logic          fail;
    logic [CW-1:0] pos_x;
    logic [CW-1:0] len_x;
    logic [60:0]   flag;
    logic [60:0]   sval;
    logic [2:0]    wlen;
    logic [3:0]    wkind;

    b        = in_if.data_byte;
    e        = in_if.chunk_end;
    pos_x    = CW'(pos_r);
    closed   = 1'b0;
    fail     = 1'b0;
    len_x    = '0;
    flag     = '0;
    sval     = '0;
    wlen     = 3'd4;
    wkind    = jtl_pkg::KIND_TRUE;

    mode_nxt = mode_r;
    idx_nxt  = idx_r;
    esc_nxt  = esc_r;
    cont_nxt = cont_r;
    spec_nxt = spec_r;
    pos_nxt  = pos_r;
    ss_nxt   = ss_r;
    acc_nxt  = acc_r;
    dcnt_nxt = dcnt_r;
    dot_nxt  = dot_r;
    frac_nxt = frac_r;
    neg_nxt  = neg_r;
    inv_nxt  = inv_r;
    nres     = 2'd0;
    res_v[0] = '0;
    res_v[1] = '0;

    if (mode_r == jtl_pkg::MODE_STRING) begin
      // Inside a string: track escapes and non-printable bytes until the closing quote.
      if ((b < jtl_pkg::CH_PRINT_LO) || (b > jtl_pkg::CH_PRINT_HI)) begin
        spec_nxt = 1'b1;
      end
      if (esc_r) begin
        esc_nxt = 1'b0;
      end else if (b == jtl_pkg::CH_BSLASH) begin
        esc_nxt  = 1'b1;
        spec_nxt = 1'b1;
      end else if (b == jtl_pkg::CH_QUOTE) begin
        closed = 1'b1;
      end
      if (closed) begin
        // A continued string reports "final part"; otherwise clean is all ones (-1).
        flag  = cont_r ? 61'd1 : (spec_nxt ? 61'd0 : '1);
        len_x = pos_x - CW'(ss_nxt);
        res_v[nres[0]] = jpkg_tok(jtl_pkg::KIND_STRING, CW'(ss_nxt), len_x, flag);
        nres     = nres + 2'd1;
        mode_nxt = jtl_pkg::MODE_BASE;
      end else if (e) begin
        len_x = pos_x + CW'(1) - CW'(ss_nxt);
        res_v[nres[0]] = jpkg_tok(jtl_pkg::KIND_STR_PART, CW'(ss_nxt), len_x, 61'd0);
        nres     = nres + 2'd1;
        cont_nxt = 1'b1;
      end
    end else if (mode_r != jtl_pkg::MODE_ERROR) begin
      // Literal words: match byte by byte, then require a delimiter after the word.
      if ((mode_r == jtl_pkg::MODE_TRUE) || (mode_r == jtl_pkg::MODE_FALSE) ||
          (mode_r == jtl_pkg::MODE_NULL)) begin
        wlen  = (mode_r == jtl_pkg::MODE_FALSE) ? 3'd5 : 3'd4;
        wkind = (mode_r == jtl_pkg::MODE_TRUE) ? jtl_pkg::KIND_TRUE :
                ((mode_r == jtl_pkg::MODE_FALSE) ? jtl_pkg::KIND_FALSE : jtl_pkg::KIND_NULL);
        if (idx_r >= wlen) begin
          if (jtl_pkg::is_gap(b) || (b == jtl_pkg::CH_RBRACKET) ||
              (b == jtl_pkg::CH_RBRACE)) begin
            res_v[nres[0]] = jpkg_tok(wkind, pos_x, CW'(idx_r), 61'd0);
            nres     = nres + 2'd1;
            mode_nxt = jtl_pkg::MODE_BASE;
          end else begin
            fail = 1'b1;
          end
        end else if (jtl_pkg::word_char(mode_r, idx_r) != b) begin
          fail = 1'b1;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
        if (fail) begin
          res_v[nres[0]] = jpkg_tok(jtl_pkg::KIND_ERROR, pos_x, CW'(0), 61'd0);
          nres     = nres + 2'd1;
          mode_nxt = jtl_pkg::MODE_ERROR;
        end
      end

      // A byte that cannot belong to a number closes it; the byte is then lexed again.
      if ((mode_nxt == jtl_pkg::MODE_NUMBER) && !jtl_pkg::is_numch(b)) begin
        if (inv_r) begin
          len_x = pos_x - CW'(ss_nxt);
          res_v[nres[0]] = jpkg_tok(jtl_pkg::KIND_NUMBER, CW'(ss_nxt), len_x,
                                    {60'd0, cont_r});
        end else begin
          sval = neg_r ? (61'd0 - {1'b0, acc_r}) : {1'b0, acc_r};
          res_v[nres[0]] = jpkg_tok(jtl_pkg::KIND_SMALL_NUM, CW'(ss_nxt), CW'(frac_r), sval);
        end
        nres     = nres + 2'd1;
        mode_nxt = jtl_pkg::MODE_BASE;
      end

      // Base byte: structural tokens, starts of strings, words and numbers.
      if (mode_nxt == jtl_pkg::MODE_BASE) begin
        if (jtl_pkg::is_gap(b)) begin
          // Whitespace, colon and comma produce nothing.
        end else if (b == jtl_pkg::CH_LBRACE) begin
          res_v[nres[0]] = jpkg_tok(jtl_pkg::KIND_LBRACE, pos_x, CW'(1), 61'd0);
          nres = nres + 2'd1;
        end else if (b == jtl_pkg::CH_RBRACE) begin
          res_v[nres[0]] = jpkg_tok(jtl_pkg::KIND_RBRACE, pos_x, CW'(1), 61'd0);
          nres = nres + 2'd1;
        end else if (b == jtl_pkg::CH_LBRACKET) begin
          res_v[nres[0]] = jpkg_tok(jtl_pkg::KIND_LBRACKET, pos_x, CW'(1), 61'd0);
          nres = nres + 2'd1;
        end else if (b == jtl_pkg::CH_RBRACKET) begin
          res_v[nres[0]] = jpkg_tok(jtl_pkg::KIND_RBRACKET, pos_x, CW'(1), 61'd0);
          nres = nres + 2'd1;
        end else if (b == jtl_pkg::CH_QUOTE) begin
          mode_nxt = jtl_pkg::MODE_STRING;
          cont_nxt = 1'b0;
          esc_nxt  = 1'b0;
          spec_nxt = 1'b0;
          ss_nxt   = {1'b0, pos_r} + (POS_W + 1)'(1);
        end else if (b == jtl_pkg::word_char(jtl_pkg::MODE_TRUE, 3'd0)) begin
          mode_nxt = jtl_pkg::MODE_TRUE;
          idx_nxt  = 3'd1;
        end else if (b == jtl_pkg::word_char(jtl_pkg::MODE_FALSE, 3'd0)) begin
          mode_nxt = jtl_pkg::MODE_FALSE;
          idx_nxt  = 3'd1;
        end else if (b == jtl_pkg::word_char(jtl_pkg::MODE_NULL, 3'd0)) begin
          mode_nxt = jtl_pkg::MODE_NULL;
          idx_nxt  = 3'd1;
        end else if (jtl_pkg::is_numch(b)) begin
          mode_nxt = jtl_pkg::MODE_NUMBER;
          cont_nxt = 1'b0;
          ss_nxt   = {1'b0, pos_r};
          acc_nxt  = '0;
          dcnt_nxt = '0;
          dot_nxt  = 1'b0;
          frac_nxt = '0;
          neg_nxt  = 1'b0;
          inv_nxt  = 1'b0;
        end else begin
          res_v[nres[0]] = jpkg_tok(jtl_pkg::KIND_ERROR, pos_x, CW'(0), 61'd0);
          nres     = nres + 2'd1;
          mode_nxt = jtl_pkg::MODE_ERROR;
        end
      end

      // Number body: a leading minus, at most lim digits and at most one dot keep it small.
      if ((mode_nxt == jtl_pkg::MODE_NUMBER) && jtl_pkg::is_numch(b)) begin
        if (!inv_nxt) begin
          if ((pos_x == CW'(ss_nxt)) && (b == jtl_pkg::CH_MINUS)) begin
            neg_nxt = 1'b1;
          end else if (jtl_pkg::is_digit(b)) begin
            dcnt_nxt = dcnt_nxt + 5'd1;
            acc_nxt  = (acc_nxt << 3) + (acc_nxt << 1) + 60'(b - jtl_pkg::CH_ZERO);
            if (dot_nxt) begin
              frac_nxt = frac_nxt + 5'd1;
            end
          end else if ((b == jtl_pkg::CH_DOT) && !dot_nxt) begin
            dot_nxt = 1'b1;
          end else begin
            inv_nxt = 1'b1;
          end
          if (dcnt_nxt > lim) begin
            inv_nxt = 1'b1;
          end
        end
        if (e) begin
          // The rest of a number split across chunks always comes out as a span.
          len_x = pos_x + CW'(1) - CW'(ss_nxt);
          res_v[nres[0]] = jpkg_tok(jtl_pkg::KIND_NUM_PART, CW'(ss_nxt), len_x,
                                    {60'd0, cont_nxt});
          nres     = nres + 2'd1;
          cont_nxt = 1'b1;
          inv_nxt  = 1'b1;
        end
      end
    end

    if (nres == 2'd1) begin
      res_v[0].last_of_run = 1'b1;
    end else if (nres == 2'd2) begin
      res_v[1].last_of_run = 1'b1;
    end

    // Offsets restart at every chunk and stick at the top of their range.
    if (e) begin
      pos_nxt  = '0;
      ss_nxt   = '0;
      spec_nxt = 1'b0;
    end else if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  // Builds a token from CW-bit offset and length values, keeping the field widths.
  function automatic jtl_pkg::tok_t jpkg_tok(input logic [3:0] kind, input logic [CW-1:0] start,
                                             input logic [CW-1:0] len, input logic [60:0] extra);
    return jtl_pkg::mk_tok(kind, start[15:0], len[16:0], extra);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jtl_pkg::MODE_BASE;
      idx_r  <= '0;
      esc_r  <= 1'b0;
      cont_r <= 1'b0;
      spec_r <= 1'b0;
      pos_r  <= '0;
      ss_r   <= '0;
      acc_r  <= '0;
      dcnt_r <= '0;
      dot_r  <= 1'b0;
      frac_r <= '0;
      neg_r  <= 1'b0;
      inv_r  <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      idx_r  <= idx_nxt;
      esc_r  <= esc_nxt;
      cont_r <= cont_nxt;
      spec_r <= spec_nxt;
      pos_r  <= pos_nxt;
      ss_r   <= ss_nxt;
      acc_r  <= acc_nxt;
      dcnt_r <= dcnt_nxt;
      dot_r  <= dot_nxt;
      frac_r <= frac_nxt;
      neg_r  <= neg_nxt;
      inv_r  <= inv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_digits_r <= jtl_pkg::DIGITS_RST;
    end else if (cfg_we) begin
      max_digits_r <= cfg_wdata;
    end
  end

  // Queue pointers: up to two tokens go in and one comes out per cycle while out_if.ready is high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + (accept ? jtl_pkg::FIFO_AW'(nres) : '0);
      rp_r  <= rp_r + (pop ? jtl_pkg::FIFO_AW'(1) : '0);
      cnt_r <= cnt_r + (accept ? (jtl_pkg::FIFO_AW + 1)'(nres) : '0)
                     - (pop ? (jtl_pkg::FIFO_AW + 1)'(1) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (nres != 2'd0)) begin
      q_mem[wp_r] <= res_v[0];
    end
    if (accept && (nres == 2'd2)) begin
      q_mem[wp_r + jtl_pkg::FIFO_AW'(1)] <= res_v[1];
    end
  end

  assign out_if.valid        = (cnt_r != '0);
  assign out_if.token_kind   = q_mem[rp_r].token_kind;
  assign out_if.token_start  = q_mem[rp_r].token_start;
  assign out_if.token_length = q_mem[rp_r].token_length;
  assign out_if.extra_value  = q_mem[rp_r].extra_value;
  assign out_if.last_of_run  = q_mem[rp_r].last_of_run;

endmodule

// ----- design/jtl_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks on the token stream of the JSON token lexer, and their bind.
// Depends on jtl_pkg for the token kind codes.
module jtl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [3:0]         token_kind,
  input logic [16:0]        token_length,
  input logic signed [60:0] extra_value,
  input logic               last_of_run
);

  // Set once an error token has been delivered; errors are sticky until reset.
  logic err_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_done_r <= 1'b0;
    end else if (out_valid && out_ready && (token_kind == jtl_pkg::KIND_ERROR)) begin
      err_done_r <= 1'b1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("token shown right after reset");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (token_kind == jtl_pkg::KIND_ERROR) |->
      (token_length == 17'd0) && (extra_value == 61'sd0) && last_of_run)
    else $error("error token with wrong fields");

  a_bracket_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((token_kind == jtl_pkg::KIND_LBRACE) || (token_kind == jtl_pkg::KIND_RBRACE) ||
                  (token_kind == jtl_pkg::KIND_LBRACKET) ||
                  (token_kind == jtl_pkg::KIND_RBRACKET)) |->
      (token_length == 17'd1) && (extra_value == 61'sd0))
    else $error("brace or bracket token with wrong fields");

  a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !err_done_r)
    else $error("token after an error was delivered");

endmodule

bind json_token_lexer jtl_checker u_jtl_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .token_kind   (out_if.token_kind),
  .token_length (out_if.token_length),
  .extra_value  (out_if.extra_value),
  .last_of_run  (out_if.last_of_run)
);

// ----- tb/tb_json_token_lexer.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the streaming JSON token lexer: JSON-like text with random chunk
// cuts goes in, tokens are predicted per accepted byte and checked in order.
// Depends on jtl_pkg, the jtl_in_if / jtl_out_if interfaces and json_token_lexer.
module tb_json_token_lexer;
  import jtl_pkg::*;

  // The chunk offset saturates one below this size.
  localparam longint unsigned CHUNK_CAP = 65536;

  // Character codes the package does not name.
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_LOW_X  = 8'h78;

  typedef struct {
    logic [7:0] ch;
    bit         last;
  } text_byte_t;

  // Tracks the lexer state byte by byte and keeps the tokens still owed by the block.
  class token_scoreboard;
    tok_t            pending_tokens[$];
    tok_t            step_tokens[$];
    int              mismatches;
    logic [4:0]      max_digits;
    mode_t           mode;
    int unsigned     word_pos;
    bit              in_escape, continued, saw_special;
    bit              saw_dot, minus, spoiled;
    longint unsigned offset, span_from, acc;
    int unsigned     digits, frac_digits;

    function new();
      mismatches  = 0;
      max_digits  = DIGITS_RST;
      mode        = MODE_BASE;
      word_pos    = 0;
      in_escape   = 1'b0;
      continued   = 1'b0;
      saw_special = 1'b0;
      saw_dot     = 1'b0;
      minus       = 1'b0;
      spoiled     = 1'b0;
      offset      = 0;
      span_from   = 0;
      acc         = 0;
      digits      = 0;
      frac_digits = 0;
    endfunction

    function bit gap_char(logic [7:0] b);
      return b == CH_COLON || b == CH_COMMA || b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function bit numeric_char(logic [7:0] b);
      return (b >= CH_ZERO && b <= CH_NINE) || b == CH_MINUS || b == CH_DOT ||
             b == CH_PLUS || b == CH_LOW_E || b == CH_UP_E;
    endfunction

    function void add_token(logic [3:0] kind, longint unsigned start,
                            longint unsigned len, longint unsigned extra);
      tok_t t;
      t.token_kind   = kind;
      t.token_start  = start[15:0];
      t.token_length = len[16:0];
      t.extra_value  = extra[60:0];
      t.last_of_run  = 1'b0;
      step_tokens.push_back(t);
    endfunction

    function void raise_error();
      mode = MODE_ERROR;
      add_token(KIND_ERROR, offset, 0, 0);
    endfunction

    function void base_byte(logic [7:0] b);
      if (gap_char(b))
        return;
      case (b)
        CH_LBRACE:   add_token(KIND_LBRACE, offset, 1, 0);
        CH_RBRACE:   add_token(KIND_RBRACE, offset, 1, 0);
        CH_LBRACKET: add_token(KIND_LBRACKET, offset, 1, 0);
        CH_RBRACKET: add_token(KIND_RBRACKET, offset, 1, 0);
        CH_QUOTE: begin
          mode        = MODE_STRING;
          continued   = 1'b0;
          in_escape   = 1'b0;
          saw_special = 1'b0;
          span_from   = offset + 1;
        end
        "t": begin
          mode     = MODE_TRUE;
          word_pos = 1;
        end
        "f": begin
          mode     = MODE_FALSE;
          word_pos = 1;
        end
        "n": begin
          mode     = MODE_NULL;
          word_pos = 1;
        end
        default: begin
          if (numeric_char(b)) begin
            mode        = MODE_NUMBER;
            continued   = 1'b0;
            span_from   = offset;
            acc         = 0;
            digits      = 0;
            saw_dot     = 1'b0;
            frac_digits = 0;
            minus       = 1'b0;
            spoiled     = 1'b0;
          end else begin
            raise_error();
          end
        end
      endcase
    endfunction

    function void take_number_char(logic [7:0] b);
      int unsigned lim;
      lim = (max_digits > DIGIT_CAP) ? DIGIT_CAP : max_digits;
      if (spoiled)
        return;
      if (offset == span_from && b == CH_MINUS) begin
        minus = 1'b1;
      end else if (b >= CH_ZERO && b <= CH_NINE) begin
        digits++;
        acc = acc * 10 + (b - CH_ZERO);
        if (saw_dot)
          frac_digits++;
      end else if (b == CH_DOT && !saw_dot) begin
        saw_dot = 1'b1;
      end else begin
        spoiled = 1'b1;
      end
      if (digits > lim)
        spoiled = 1'b1;
    endfunction

    // Called for every byte the block accepts; queues the tokens that byte must produce.
    function void lex_byte(logic [7:0] b, bit last);
      bit              closed;
      string           spelling;
      logic [3:0]      word_kind;
      longint unsigned flag;
      step_tokens.delete();
      if (mode == MODE_STRING) begin
        closed = 1'b0;
        if (b < CH_PRINT_LO || b > CH_PRINT_HI)
          saw_special = 1'b1;
        if (in_escape) begin
          in_escape = 1'b0;
        end else if (b == CH_BSLASH) begin
          in_escape   = 1'b1;
          saw_special = 1'b1;
        end else if (b == CH_QUOTE) begin
          closed = 1'b1;
        end
        if (closed) begin
          flag = continued ? 1 : (saw_special ? 0 : '1);
          add_token(KIND_STRING, span_from, offset - span_from, flag);
          mode = MODE_BASE;
        end else if (last) begin
          add_token(KIND_STR_PART, span_from, offset + 1 - span_from, 0);
          continued = 1'b1;
        end
      end else if (mode != MODE_ERROR) begin
        if (mode == MODE_TRUE || mode == MODE_FALSE || mode == MODE_NULL) begin
          if (mode == MODE_TRUE) begin
            spelling  = "true";
            word_kind = KIND_TRUE;
          end else if (mode == MODE_FALSE) begin
            spelling  = "false";
            word_kind = KIND_FALSE;
          end else begin
            spelling  = "null";
            word_kind = KIND_NULL;
          end
          if (word_pos >= spelling.len()) begin
            if (gap_char(b) || b == CH_RBRACKET || b == CH_RBRACE) begin
              add_token(word_kind, offset, word_pos, 0);
              mode = MODE_BASE;
            end else begin
              raise_error();
            end
          end else if (spelling[word_pos] != b) begin
            raise_error();
          end else begin
            word_pos++;
          end
        end
        // A number closes on its first non-number byte, which is then lexed afresh.
        if (mode == MODE_NUMBER && !numeric_char(b)) begin
          if (spoiled)
            add_token(KIND_NUMBER, span_from, offset - span_from, continued);
          else
            add_token(KIND_SMALL_NUM, span_from, frac_digits, minus ? 0 - acc : acc);
          mode = MODE_BASE;
        end
        if (mode == MODE_BASE)
          base_byte(b);
        if (mode == MODE_NUMBER && numeric_char(b)) begin
          take_number_char(b);
          if (last) begin
            add_token(KIND_NUM_PART, span_from, offset + 1 - span_from, continued);
            continued = 1'b1;
            spoiled   = 1'b1;
          end
        end
      end
      if (step_tokens.size() > 0)
        step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
      foreach (step_tokens[i])
        pending_tokens.push_back(step_tokens[i]);
      if (last) begin
        offset      = 0;
        span_from   = 0;
        saw_special = 1'b0;
      end else if (offset + 1 < CHUNK_CAP) begin
        offset++;
      end
    endfunction

    function void check_token(tok_t got);
      tok_t want;
      if (pending_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected token kind %0d start %0d len %0d extra %0d last %0b",
                   $time, got.token_kind, got.token_start, got.token_length,
                   got.extra_value, got.last_of_run);
        return;
      end
      want = pending_tokens.pop_front();
      if (got.token_kind !== want.token_kind || got.token_start !== want.token_start ||
          got.token_length !== want.token_length || got.extra_value !== want.extra_value ||
          got.last_of_run !== want.last_of_run) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: token mismatch, expected kind %0d start %0d len %0d extra %0d ",
                    "last %0b, got kind %0d start %0d len %0d extra %0d last %0b"}, $time,
                   want.token_kind, want.token_start, want.token_length, want.extra_value,
                   want.last_of_run, got.token_kind, got.token_start, got.token_length,
                   got.extra_value, got.last_of_run);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [4:0] cfg_wdata;

  jtl_in_if  in_if();
  jtl_out_if out_if();

  json_token_lexer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  token_scoreboard sb;
  text_byte_t      text_q[$];   // bytes waiting to be offered to the lexer
  int              body_bytes;  // bytes in the current phase that carry meaning
  bit              tx_idle_on = 1'b1;
  bit              rx_idle_on = 1'b1;
  int              rx_hold = 0;  // one-off long stall requested from the token sink

  // ---------------------------------------------------------------------------
  // Text builders. Every builder appends to text_q; put_rnd and put_gap may cut
  // the chunk after the byte, so strings, numbers and words get split across
  // chunk boundaries at random points.
  // ---------------------------------------------------------------------------
  function automatic void put(input logic [7:0] ch, input bit last);
    text_byte_t t;
    t.ch   = ch;
    t.last = last;
    text_q.push_back(t);
  endfunction

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++)
      put(s[i], 1'b0);
  endfunction

  // Marks the byte appended last as the end of its chunk.
  function automatic void cut();
    text_q[text_q.size() - 1].last = 1'b1;
  endfunction

  function automatic void put_rnd(input logic [7:0] ch);
    put(ch, $urandom_range(0, 47) == 0);
    body_bytes++;
  endfunction

  // Separators and white space are skipped by the lexer, so they are not counted.
  function automatic void put_gap(input logic [7:0] ch);
    put(ch, $urandom_range(0, 47) == 0);
  endfunction

  function automatic logic [7:0] ws_char();
    return $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
  endfunction

  function automatic void maybe_ws();
    if ($urandom_range(0, 3) == 0)
      put_gap(ws_char());
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  // Strings mix printable text with escapes (any byte may follow the backslash)
  // and raw control or high bytes, which mark the string as special.
  function automatic void gen_string();
    int n;
    int r;
    logic [7:0] c;
    put_rnd(CH_QUOTE);
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
    repeat (n) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        put_rnd(CH_BSLASH);
        put_rnd(8'($urandom_range(0, 255)));
      end else if (r == 1) begin
        c = $urandom_range(0, 1) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(127, 255));
        put_rnd(c);
      end else begin
        c = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
        if (c == CH_QUOTE || c == CH_BSLASH)
          c = CH_DOT;
        put_rnd(c);
      end
    end
    put_rnd(CH_QUOTE);
  endfunction

  // Mostly plain decimal numbers, some near the digit limit, some with a long
  // fraction, and a share of random number-character runs, most of which come back as spans.
  function automatic void gen_number();
    int n;
    int r;
    bit nines;
    logic [7:0] c;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0: c = CH_MINUS;
          1: c = CH_DOT;
          2: c = CH_PLUS;
          3: c = CH_LOW_E;
          4: c = CH_UP_E;
          default: c = digit_char();
        endcase
        put_rnd(c);
      end
    end else if (r == 1) begin
      put_rnd(CH_ZERO);
      put_rnd(CH_DOT);
      repeat ($urandom_range(1, 18)) put_rnd(digit_char());
    end else begin
      if ($urandom_range(0, 2) == 0)
        put_rnd(CH_MINUS);
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 5);
      nines = ($urandom_range(0, 3) == 0);
      repeat (n) put_rnd(nines ? CH_NINE : digit_char());
      if ($urandom_range(0, 2) == 0) begin
        put_rnd(CH_DOT);
        repeat ($urandom_range(1, 4)) put_rnd(digit_char());
      end
      if ($urandom_range(0, 11) == 0) begin
        put_rnd($urandom_range(0, 1) ? CH_LOW_E : CH_UP_E);
        if ($urandom_range(0, 1))
          put_rnd($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        repeat ($urandom_range(1, 3)) put_rnd(digit_char());
      end
    end
  endfunction

  function automatic void gen_word();
    string w;
    case ($urandom_range(0, 2))
      0: w = "true";
      1: w = "false";
      default: w = "null";
    endcase
    for (int i = 0; i < w.len(); i++)
      put_rnd(w[i]);
  endfunction

  // Any value; containers nest up to three levels. Inside a container every
  // scalar is followed by a comma, a closer or white space, all of which are
  // legal delimiters for words and numbers.
  function automatic void gen_value(input int depth);
    int r;
    int n;
    r = (depth >= 3) ? $urandom_range(4, 9) : $urandom_range(0, 9);
    case (r)
      0, 1: begin
        put_rnd(CH_LBRACE);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0)
            put_gap(CH_COMMA);
          maybe_ws();
          gen_string();
          maybe_ws();
          put_gap(CH_COLON);
          maybe_ws();
          gen_value(depth + 1);
          maybe_ws();
        end
        put_rnd(CH_RBRACE);
      end
      2, 3: begin
        put_rnd(CH_LBRACKET);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
          if (i > 0)
            put_gap(CH_COMMA);
          maybe_ws();
          gen_value(depth + 1);
        end
        put_rnd(CH_RBRACKET);
      end
      4, 5: gen_string();
      6, 7: gen_number();
      default: gen_word();
    endcase
  endfunction

  // One top-level document. A few are broken on purpose: stray closers or bare
  // numbers, which the lexer must still report without leaving its normal modes.
  function automatic void gen_doc();
    case ($urandom_range(0, 7))
      0: put_rnd($urandom_range(0, 1) ? CH_RBRACKET : CH_RBRACE);
      1: gen_number();
      default: gen_value(0);
    endcase
    put_gap(ws_char());
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Inputs change only through nonblocking assignments right after a
  // rising edge; handshakes are sampled at the edge, before those updates land.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] ch, input bit last, input bit gapless);
    int gap;
    gap = (gapless || !tx_idle_on) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= ch;
    in_if.chunk_end <= last;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    sb.lex_byte(ch, last);
  endtask

  task automatic send_text(input bit gapless);
    foreach (text_q[i])
      send_byte(text_q[i].ch, text_q[i].last, gapless);
    text_q.delete();
  endtask

  // Stops offering bytes and waits for every owed token. A byte that yields no
  // token may still be in flight, so the task waits on further edges before returning.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Only called while the lexer is idle.
  task automatic set_max_digits(input logic [4:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.max_digits = v;
  endtask

  task automatic random_phase(input logic [4:0] digits_cfg, input int target);
    set_max_digits(digits_cfg);
    body_bytes = 0;
    while (body_bytes < target) begin
      // Most documents see idling on both sides; some go through back to back.
      tx_idle_on = ($urandom_range(0, 4) != 0);
      rx_idle_on = ($urandom_range(0, 4) != 0);
      gen_doc();
      send_text(1'b0);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    settle();
  endtask

  // Token sink: waits a random number of cycles before taking each token, and
  // serves the one long stall that fills the lexer's queue.
  initial begin : token_sink
    int gap;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_if.ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      gap = rx_idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!(out_if.valid === 1'b1 && out_if.ready === 1'b1)) @(posedge clk);
    end
  end

  // Every token taken at an edge is checked against the oldest owed one.
  always @(posedge clk) begin : token_monitor
    tok_t got;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.token_kind   = out_if.token_kind;
      got.token_start  = out_if.token_start;
      got.token_length = out_if.token_length;
      got.extra_value  = out_if.extra_value;
      got.last_of_run  = out_if.last_of_run;
      sb.check_token(got);
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #(2_000_000);
    $display("[json_token_lexer] ERROR");
    $finish;
  end

  initial begin : stimulus
    in_if.valid     <= 1'b0;
    in_if.data_byte <= 8'h00;
    in_if.chunk_end <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= 5'd0;
    rst_n           <= 1'b0;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed text. The first piece gives an empty clean string and a word
    // closed by a brace, which yields two tokens from one byte. The second has
    // an escaped quote with the bytes 0x00 and 0xFF (a special string), a word
    // split across chunks, a string part followed by its final part, and a
    // number part whose rest comes back as a continued span closed by a bracket.
    set_max_digits(DIGIT_CAP);
    put_str("{\"\":false}");
    put_str("[\"\\\"");
    put(8'h00, 1'b0);
    put(8'hFF, 1'b0);
    put_str("\",tru");
    cut();
    put_str("e,\"b");
    cut();
    put_str("c\",12");
    cut();
    put_str("3.4]");
    cut();
    send_text(1'b0);
    settle();

    random_phase(DIGIT_CAP, 95);

    // Long stall on the token side while a burst of brackets keeps coming; the
    // lexer queue fills and the byte side must be held off.
    rx_hold = 80;
    repeat (24) put(CH_LBRACKET, 1'b0);
    repeat (24) put(CH_RBRACKET, 1'b0);
    send_text(1'b1);
    settle();

    random_phase(5'd1, 95);
    random_phase(5'd0, 95);
    random_phase(5'd31, 95);
    random_phase(5'($urandom_range(2, 17)), 95);
    random_phase(5'($urandom_range(0, 31)), 95);

    // An error is sticky until reset, so only one kind of it can be shown per
    // run: an unknown byte, a wrong letter inside a word, or a bad byte right
    // after a word. Everything after it must be ignored.
    case ($urandom_range(0, 2))
      0: put(CH_AT, 1'b0);
      1: put_str("trx");
      default: begin
        put_str("null");
        put(CH_LOW_X, 1'b0);
      end
    endcase
    repeat (40) put(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    send_text(1'b0);
    settle();

    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_tokens.size() == 0)
      $display("[json_token_lexer] OK");
    else
      $display("[json_token_lexer] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
design/jtl_pkg.sv
design/jtl_in_if.sv
design/jtl_out_if.sv
design/json_token_lexer.sv
design/jtl_checker.sv
tb/tb_json_token_lexer.sv
